// ===== hdl/utcc_pkg.sv =====
// ----------------------------------------------------------------------------
// utcc_pkg: shared constants, types and helpers for the Unix time converter
// Holds the epoch limits, the per-stage payload struct and the
// constant-divisor helpers (reciprocal multiply) used by the pipeline.
// ----------------------------------------------------------------------------
package utcc_pkg;

  // Number of pipeline stages from request capture to result register
  localparam int unsigned NumStages = 8;

  localparam logic [31:0] Epoch2000  = 32'd946684800;
  localparam logic [31:0] Epoch2100  = 32'd4102444800;
  localparam logic [31:0] SecsPerDay = 32'd86400;

  // Calendar clamp limits
  localparam logic [3:0] MonthMax  = 4'd12;
  localparam logic [4:0] HourMax   = 5'd23;
  localparam logic [5:0] MinuteMax = 6'd60;
  localparam logic [5:0] SecondMax = 6'd60;

  // Reciprocals for the constant divisions
  localparam logic [25:0] Recip675  = 26'd50903316; // floor(2^35 / 675)
  localparam logic [15:0] Recip15   = 16'd34953;    // ceil(2^19 / 15)
  localparam logic [16:0] Recip7    = 17'd74899;    // ceil(2^19 / 7)
  localparam logic [15:0] Recip1461 = 16'd45934;    // ceil(2^26 / 1461)

  // Payload carried down the pipeline; each stage fills in more fields
  typedef struct packed {
    logic        func;
    logic        err;
    logic [31:0] secs;     // seconds in, or composed seconds
    logic [31:0] t;        // seconds since 2000-01-01
    logic [15:0] days;     // whole days since 2000-01-01
    logic [16:0] sod;      // second of day
    logic [10:0] mtot;     // minute of day
    logic [4:0]  cyc;      // four-year cycle number
    logic [10:0] r1461;    // day within the four-year cycle
    logic [8:0]  doy;      // day of year, from zero
    logic        leap;
    logic [15:0] dayplus;  // day count plus one (compose)
    logic [31:0] prod;     // dayplus times seconds per day (compose)
    logic [16:0] hms;      // seconds within the day (compose)
    logic [6:0]  yo;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [4:0]  hr;
    logic [5:0]  mi;
    logic [5:0]  se;
    logic [2:0]  wd;
  } stage_t;

  // Days before the first of a month (1..12); zero for anything else
  function automatic logic [8:0] month_start(input logic [3:0] mo);
    logic [8:0] r;
    case (mo)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Estimate of x / 675, low by at most one
  function automatic logic [15:0] div675_est(input logic [24:0] x);
    logic [50:0] p;
    p = 51'(x) * 51'(Recip675);
    return p[50:35];
  endfunction

  // Exact x / 60 for x below 122880 (the quotient must fit in 11 bits)
  function automatic logic [10:0] div60(input logic [16:0] x);
    logic [30:0] p;
    p = 31'(x[16:2]) * 31'(Recip15);
    return p[29:19];
  endfunction

  // Exact y mod 7 for any 16-bit y
  function automatic logic [2:0] mod7(input logic [15:0] y);
    logic [32:0] p;
    logic [13:0] q;
    logic [15:0] r;
    p = 33'(y) * 33'(Recip7);
    q = p[32:19];
    r = y - {q[12:0], 3'b000} + {2'b00, q};
    return r[2:0];
  endfunction

  // Exact y / 1461 for y below 36525
  function automatic logic [4:0] div1461(input logic [15:0] y);
    logic [41:0] p;
    p = 42'(y) * 42'(Recip1461);
    return p[30:26];
  endfunction

endpackage

// ===== hdl/unix_time_calendar_converter.sv =====
// ----------------------------------------------------------------------------
// unix_time_calendar_converter: Unix seconds to/from calendar, 2000 to 2099
// Splits a timestamp into date, time and weekday, or composes calendar fields,
// month and time clamped, into seconds and weekday, in an eight-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   | signals                          | handshake
//  ----------+----------------------------------+-------------------------------
//  request   | func_i, seconds_in_i, *_in_i     | taken when start && !busy
//  result    | seconds_out_o .. range_error_o   | valid one cycle with done_o
//
//  One request per cycle; the result passes through the eight register stages
//  (range check and clamp, a reciprocal-multiply day estimate and its
//  correction, then minute, weekday, year, month and day steps) and is
//  on the ports while done_o is high.
//  busy stays low: every stage advances each cycle and nothing backs up.
//  Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
module unix_time_calendar_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [31:0] seconds_in_i,
  input  logic [6:0]  year_offset_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [4:0]  day_in_i,
  input  logic [4:0]  hour_in_i,
  input  logic [5:0]  minute_in_i,
  input  logic [5:0]  second_in_i,
  output logic        done_o,
  output logic [31:0] seconds_out_o,
  output logic [6:0]  year_offset_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic [2:0]  weekday_o,
  output logic        range_error_o
);

  localparam int unsigned NS = utcc_pkg::NumStages;

  logic            accept;
  logic [NS:1]     vld_q;
  utcc_pkg::stage_t s1_d, s2_d, s3_d, s4_d, s5_d, s6_d, s7_d, s8_d;
  utcc_pkg::stage_t s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q, s8_q;

  // The pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: clamp calendar fields, check range, offset to 2000
  always_comb begin
    s1_d         = '0;
    s1_d.func    = func_i;
    s1_d.secs    = seconds_in_i;
    s1_d.err     = !func_i && ((seconds_in_i < utcc_pkg::Epoch2000) ||
                               (seconds_in_i >= utcc_pkg::Epoch2100));
    s1_d.t       = seconds_in_i - utcc_pkg::Epoch2000;
    s1_d.yo      = year_offset_in_i;
    s1_d.mo      = (month_in_i > utcc_pkg::MonthMax) ? utcc_pkg::MonthMax : month_in_i;
    s1_d.dy      = day_in_i;
    s1_d.hr      = (hour_in_i > utcc_pkg::HourMax) ? utcc_pkg::HourMax : hour_in_i;
    s1_d.mi      = (minute_in_i > utcc_pkg::MinuteMax) ? utcc_pkg::MinuteMax : minute_in_i;
    s1_d.se      = (second_in_i > utcc_pkg::SecondMax) ? utcc_pkg::SecondMax : second_in_i;
  end

  // Stage 2: estimate days, build composed day count
  always_comb begin
    logic [7:0] yq;
    s2_d         = s1_q;
    yq           = (8'(s1_q.yo) + 8'd3) >> 2;
    s2_d.days    = utcc_pkg::div675_est(s1_q.t[31:7]);
    s2_d.dayplus = 16'(s1_q.dy) + 16'(utcc_pkg::month_start(s1_q.mo))
                 + 16'((s1_q.mo > 4'd2) && (s1_q.yo[1:0] == 2'b00))
                 + 16'(s1_q.yo) * 16'd365 + 16'(yq);
  end

  // Stage 3: correct day estimate, form second of day; compose products
  always_comb begin
    logic [24:0] rem;
    s3_d      = s2_q;
    rem       = s2_q.t[31:7] - 25'(s2_q.days) * 25'd675;
    if (rem >= 25'd675) begin
      s3_d.days = s2_q.days + 16'd1;
      rem       = rem - 25'd675;
    end
    s3_d.sod  = {rem[9:0], s2_q.t[6:0]};
    s3_d.prod = 32'(s2_q.dayplus) * utcc_pkg::SecsPerDay;
    s3_d.hms  = 17'(s2_q.hr) * 17'd3600 + 17'(s2_q.mi) * 17'd60 + 17'(s2_q.se);
  end

  // Stage 4: minute of day, cycle number, weekday; composed seconds
  always_comb begin
    s4_d      = s3_q;
    s4_d.mtot = utcc_pkg::div60(s3_q.sod);
    s4_d.cyc  = utcc_pkg::div1461(s3_q.days);
    if (s3_q.func) begin
      s4_d.secs = (utcc_pkg::Epoch2000 - utcc_pkg::SecsPerDay) + s3_q.prod
                + 32'(s3_q.hms);
      s4_d.wd   = utcc_pkg::mod7(s3_q.dayplus + 16'd5);
    end else begin
      s4_d.wd   = utcc_pkg::mod7(s3_q.days + 16'd6);
    end
  end

  // Stage 5: seconds and hours, day within the four-year cycle
  always_comb begin
    s5_d       = s4_q;
    s5_d.r1461 = 11'(s4_q.days - 16'(s4_q.cyc) * 16'd1461);
    if (!s4_q.func) begin
      s5_d.se = 6'(s4_q.sod - 17'(s4_q.mtot) * 17'd60);
      s5_d.hr = 5'(utcc_pkg::div60(17'(s4_q.mtot)));
    end
  end

  // Stage 6: minutes, year within the cycle, day of year
  always_comb begin
    logic [1:0] yr;
    s6_d = s5_q;
    if (s5_q.r1461 >= 11'd1096) begin
      yr = 2'd3;
    end else if (s5_q.r1461 >= 11'd731) begin
      yr = 2'd2;
    end else if (s5_q.r1461 >= 11'd366) begin
      yr = 2'd1;
    end else begin
      yr = 2'd0;
    end
    s6_d.leap = (yr == 2'd0);
    s6_d.doy  = (yr == 2'd0) ? s5_q.r1461[8:0]
              : 9'(s5_q.r1461 - 11'd1 - 11'(yr) * 11'd365);
    if (!s5_q.func) begin
      s6_d.mi = 6'(s5_q.mtot - 11'(s5_q.hr) * 11'd60);
      s6_d.yo = {s5_q.cyc, yr};
    end
  end

  // Stage 7: month search against the start-of-month table
  always_comb begin
    logic [8:0] thr;
    logic [3:0] cnt;
    s7_d = s6_q;
    cnt  = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      thr = utcc_pkg::month_start(4'(k)) + 9'(s6_q.leap && (k > 2));
      if (s6_q.doy >= thr) begin
        cnt = cnt + 4'd1;
      end
    end
    if (!s6_q.func) begin
      s7_d.mo = cnt;
    end
  end

  // Stage 8: day of month, zero the calendar on range error
  always_comb begin
    logic [8:0] mst;
    s8_d = s7_q;
    mst  = utcc_pkg::month_start(s7_q.mo) + 9'(s7_q.leap && (s7_q.mo > 4'd2));
    if (!s7_q.func) begin
      s8_d.dy = 5'(s7_q.doy - mst + 9'd1);
    end
    if (s7_q.err) begin
      s8_d.yo = '0;
      s8_d.mo = '0;
      s8_d.dy = '0;
      s8_d.hr = '0;
      s8_d.mi = '0;
      s8_d.se = '0;
      s8_d.wd = '0;
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-1:1], accept};
    end
  end

  // Advance the payload of occupied stages
  always_ff @(posedge clk_i) begin
    if (accept)   s1_q <= s1_d;
    if (vld_q[1]) s2_q <= s2_d;
    if (vld_q[2]) s3_q <= s3_d;
    if (vld_q[3]) s4_q <= s4_d;
    if (vld_q[4]) s5_q <= s5_d;
    if (vld_q[5]) s6_q <= s6_d;
    if (vld_q[6]) s7_q <= s7_d;
    if (vld_q[7]) s8_q <= s8_d;
  end

  // Drive the result
  assign done_o            = vld_q[NS];
  assign seconds_out_o     = s8_q.secs;
  assign year_offset_out_o = s8_q.yo;
  assign month_out_o       = s8_q.mo;
  assign day_out_o         = s8_q.dy;
  assign hour_out_o        = s8_q.hr;
  assign minute_out_o      = s8_q.mi;
  assign second_out_o      = s8_q.se;
  assign weekday_o         = s8_q.wd;
  assign range_error_o     = s8_q.err;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for unix_time_calendar_converter
// Drives timestamp split and calendar compose requests, directed edges first
// and then random traffic under several sender idle patterns. A behavioral
// calendar model predicts every result, and a monitor compares each strobed
// result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PrintLimit = 40;

  // One request as seen on the input ports
  typedef struct packed {
    logic        func;
    logic [31:0] secs;
    logic [6:0]  yo;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [4:0]  hr;
    logic [5:0]  mi;
    logic [5:0]  se;
  } req_t;

  // One calendar result as seen on the output ports
  typedef struct packed {
    logic [31:0] secs;
    logic [6:0]  yo;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [4:0]  hr;
    logic [5:0]  mi;
    logic [5:0]  se;
    logic [2:0]  wd;
    logic        err;
  } cal_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        func;
  logic [31:0] seconds_in;
  logic [6:0]  year_offset_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic [4:0]  hour_in;
  logic [5:0]  minute_in;
  logic [5:0]  second_in;
  logic        done;
  logic [31:0] seconds_out;
  logic [6:0]  year_offset_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic [2:0]  weekday;
  logic        range_error;

  cal_t        calendar_fifo[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned split_count;
  int unsigned compose_count;
  int unsigned out_of_range_count;

  int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int unsigned days_before[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  unix_time_calendar_converter dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start            (start),
    .busy             (busy),
    .func_i           (func),
    .seconds_in_i     (seconds_in),
    .year_offset_in_i (year_offset_in),
    .month_in_i       (month_in),
    .day_in_i         (day_in),
    .hour_in_i        (hour_in),
    .minute_in_i      (minute_in),
    .second_in_i      (second_in),
    .done_o           (done),
    .seconds_out_o    (seconds_out),
    .year_offset_out_o(year_offset_out),
    .month_out_o      (month_out),
    .day_out_o        (day_out),
    .hour_out_o       (hour_out),
    .minute_out_o     (minute_out),
    .second_out_o     (second_out),
    .weekday_o        (weekday),
    .range_error_o    (range_error)
  );

  // Generate the clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Compute the calendar result for one request
  function automatic cal_t predict_calendar(input req_t r);
    cal_t            c;
    int unsigned     t;
    int unsigned     days;
    int unsigned     year;
    int unsigned     month;
    int unsigned     span;
    int unsigned     dayplus;
    int unsigned     mo;
    int unsigned     hr;
    int unsigned     mi;
    int unsigned     se;
    bit              leap;
    longint unsigned total;
    c = '0;
    if (!r.func) begin
      c.secs = r.secs;
      if (r.secs < utcc_pkg::Epoch2000 || r.secs >= utcc_pkg::Epoch2100) begin
        c.err = 1'b1;
      end else begin
        t = r.secs - utcc_pkg::Epoch2000;
        c.se = 6'(t % 60);
        t = t / 60;
        c.mi = 6'(t % 60);
        t = t / 60;
        c.hr = 5'(t % 24);
        days = t / 24;
        c.wd = 3'((days + 6) % 7);
        // Walk whole years, then whole months
        year = 0;
        leap = 1'b1;
        while (1) begin
          leap = (year % 4) == 0;
          span = leap ? 366 : 365;
          if (days < span || year >= 99) break;
          days = days - span;
          year++;
        end
        month = 1;
        while (1) begin
          span = month_days[month - 1] + ((leap && month == 2) ? 1 : 0);
          if (days < span || month >= 12) break;
          days = days - span;
          month++;
        end
        c.yo = 7'(year);
        c.mo = 4'(month);
        c.dy = 5'(days + 1);
      end
    end else begin
      // Clamp the fields, then count days from the start of 2000
      mo = (r.mo > 12) ? 12 : r.mo;
      hr = (r.hr > 23) ? 23 : r.hr;
      mi = (r.mi > 60) ? 60 : r.mi;
      se = (r.se > 60) ? 60 : r.se;
      dayplus = r.dy;
      if (mo >= 1) dayplus += days_before[mo - 1];
      if (mo > 2 && (r.yo % 4) == 0) dayplus++;
      dayplus += 365 * r.yo + (r.yo + 3) / 4;
      total = 64'(utcc_pkg::Epoch2000) + 64'(dayplus) * 86400 - 86400
            + hr * 3600 + mi * 60 + se;
      c.secs = 32'(total);
      c.yo = r.yo;
      c.mo = 4'(mo);
      c.dy = r.dy;
      c.hr = 5'(hr);
      c.mi = 6'(mi);
      c.se = 6'(se);
      c.wd = 3'((dayplus + 5) % 7);
    end
    return c;
  endfunction

  // Build a compose request; the unused timestamp carries noise
  function automatic req_t make_date(input int unsigned yo, input int unsigned mo,
                                     input int unsigned dy, input int unsigned hr,
                                     input int unsigned mi, input int unsigned se);
    req_t r;
    r.func = 1'b1;
    r.secs = $urandom();
    r.yo = 7'(yo);
    r.mo = 4'(mo);
    r.dy = 5'(dy);
    r.hr = 5'(hr);
    r.mi = 6'(mi);
    r.se = 6'(se);
    return r;
  endfunction

  // Build a random request, mostly well formed, some wild
  function automatic req_t random_request(input bit compose);
    req_t        r;
    req_t        anchor;
    cal_t        c;
    int unsigned pick;
    r = make_date($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    r.func = compose;
    pick = $urandom_range(99);
    if (!compose) begin
      if (pick < 65) begin
        r.secs = $urandom_range(utcc_pkg::Epoch2100 - 1, utcc_pkg::Epoch2000);
      end else if (pick < 85) begin
        // Land near a month or year boundary
        anchor = make_date($urandom_range(99), $urandom_range(12, 1),
                           $urandom_range(1) ? 1 : $urandom_range(31, 28),
                           0, 0, 0);
        if ($urandom_range(1)) begin
          anchor.hr = 23;
          anchor.mi = 59;
          anchor.se = 59;
        end
        c = predict_calendar(anchor);
        r.secs = c.secs + $urandom_range(4) - 2;
      end
    end else if (pick < 80) begin
      r.yo = 7'($urandom_range(99));
      r.mo = 4'($urandom_range(12, 1));
      r.dy = 5'($urandom_range(31, 1));
      r.hr = 5'($urandom_range(23));
      r.mi = 6'($urandom_range(59));
      r.se = 6'($urandom_range(59));
    end
    return r;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < PrintLimit)
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Idle a random gap, then drive one request and hold it until taken
  task automatic send_request(input req_t r, input int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(10, 1);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    func <= r.func;
    seconds_in <= r.secs;
    year_offset_in <= r.yo;
    month_in <= r.mo;
    day_in <= r.dy;
    hour_in <= r.hr;
    minute_in <= r.mi;
    second_in <= r.se;
    @(posedge clk);
    while (busy) begin
      @(negedge clk);
      @(posedge clk);
    end
  endtask

  // Check each strobed result, then record each accepted request
  always @(posedge clk) begin : check_results
    cal_t want;
    req_t taken;
    if (rst_n) begin
      if (done) begin
        if (calendar_fifo.size() == 0) begin
          report_mismatch("result with nothing pending", seconds_out, 0);
        end else begin
          want = calendar_fifo.pop_front();
          if (seconds_out !== want.secs) report_mismatch("seconds", seconds_out, want.secs);
          if (year_offset_out !== want.yo) report_mismatch("year", year_offset_out, want.yo);
          if (month_out !== want.mo) report_mismatch("month", month_out, want.mo);
          if (day_out !== want.dy) report_mismatch("day", day_out, want.dy);
          if (hour_out !== want.hr) report_mismatch("hour", hour_out, want.hr);
          if (minute_out !== want.mi) report_mismatch("minute", minute_out, want.mi);
          if (second_out !== want.se) report_mismatch("second", second_out, want.se);
          if (weekday !== want.wd) report_mismatch("weekday", weekday, want.wd);
          if (range_error !== want.err) report_mismatch("range error", range_error, want.err);
          if (want.err) out_of_range_count++;
        end
      end
      if (start && !busy) begin
        taken = '{func, seconds_in, year_offset_in, month_in, day_in, hour_in,
                  minute_in, second_in};
        calendar_fifo.push_back(predict_calendar(taken));
        if (func) compose_count++;
        else split_count++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               calendar_fifo.size());
      $display("[unix_time_calendar_converter] ERROR");
      $finish;
    end
  end

  // Split timestamps at the range limits and at leap year days
  task automatic test_timestamp_edges();
    logic [31:0] stamps[9];
    req_t        r;
    stamps = '{32'd0, utcc_pkg::Epoch2000 - 1, utcc_pkg::Epoch2000, 32'd951782400,
               32'd978307199, 32'd978307200, utcc_pkg::Epoch2100 - 1,
               utcc_pkg::Epoch2100, 32'hFFFF_FFFF};
    foreach (stamps[i]) begin
      r = make_date($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      r.func = 1'b0;
      r.secs = stamps[i];
      send_request(r, 0);
    end
  endtask

  // Compose dates with clamped fields, month zero, day zero and large years
  task automatic test_calendar_edges();
    send_request(make_date(0, 0, 0, 0, 0, 0), 0);
    send_request(make_date(0, 1, 1, 0, 0, 0), 0);
    send_request(make_date(0, 2, 29, 12, 30, 30), 0);
    send_request(make_date(0, 3, 1, 0, 0, 0), 0);
    send_request(make_date(1, 3, 1, 0, 0, 0), 0);
    send_request(make_date(4, 3, 0, 1, 1, 1), 0);
    send_request(make_date(99, 12, 31, 23, 59, 59), 0);
    send_request(make_date(127, 15, 31, 31, 63, 63), 0);
    send_request(make_date(50, 13, 15, 24, 60, 60), 0);
    send_request(make_date(23, 2, 31, 23, 61, 61), 0);
    send_request(make_date(100, 6, 10, 5, 5, 5), 0);
    send_request(make_date(3, 0, 10, 7, 0, 0), 0);
  endtask

  // Split random timestamps
  task automatic test_split_timestamps(input int unsigned count, input int unsigned idle_pct);
    repeat (count) send_request(random_request(1'b0), idle_pct);
  endtask

  // Compose random calendar dates
  task automatic test_compose_dates(input int unsigned count, input int unsigned idle_pct);
    repeat (count) send_request(random_request(1'b1), idle_pct);
  endtask

  // Interleave both directions
  task automatic test_mixed_requests(input int unsigned count, input int unsigned idle_pct);
    repeat (count) send_request(random_request($urandom_range(1)), idle_pct);
  endtask

  // Drain the pipeline and report
  task automatic finish_run();
    int unsigned waited;
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (calendar_fifo.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (utcc_pkg::NumStages + 4) @(posedge clk);
    if (calendar_fifo.size() != 0)
      report_mismatch("results never returned", 0, calendar_fifo.size());
    $display("covered %0d timestamp splits (%0d out of range) and %0d date composes",
             split_count, out_of_range_count, compose_count);
    $display("sender idle at 0, 54 and 24 percent; %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("[unix_time_calendar_converter] OK");
    end else begin
      $display("[unix_time_calendar_converter] ERROR");
    end
    $finish;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    func = 1'b0;
    seconds_in = '0;
    year_offset_in = '0;
    month_in = '0;
    day_in = '0;
    hour_in = '0;
    minute_in = '0;
    second_in = '0;
    mismatch_count = 0;
    cycle_count = 0;
    split_count = 0;
    compose_count = 0;
    out_of_range_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_timestamp_edges();
    test_calendar_edges();
    test_split_timestamps(450, 0);
    test_compose_dates(450, 54);
    test_mixed_requests(450, 24);
    test_mixed_requests(450, 0);
    finish_run();
  end

endmodule
